>>> rtl/i2c_mts_pkg.sv
// shared types and constants for the i2c master transfer sequencer
// no dependencies; used by the interfaces, the core and the top level
package i2c_mts_pkg;

    localparam int CHUNK_MAX_DEF   = 255;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int ADDR_W  = 10;
    localparam int CNT_W   = 16;
    localparam int FLAG_W  = 9;
    localparam int ERR_W   = 5;
    localparam int CHUNK_W = 8;

    // function codes of a request
    localparam logic [1:0] FUNC_START_WR = 2'd0;
    localparam logic [1:0] FUNC_START_RD = 2'd1;
    localparam logic [1:0] FUNC_EVENT    = 2'd2;

    // status flag positions
    localparam int FLAG_NACK     = 0;
    localparam int FLAG_RELOAD   = 1;
    localparam int FLAG_COMPLETE = 2;
    localparam int FLAG_BUS      = 3;
    localparam int FLAG_ARB      = 4;
    localparam int FLAG_OVR      = 5;
    localparam int FLAG_TIMEOUT  = 6;
    localparam int FLAG_OTHER_ER = 7;
    localparam int FLAG_OTHER    = 8;

    // error accumulator positions
    localparam int ERR_ACK     = 0;
    localparam int ERR_BUS     = 1;
    localparam int ERR_ARB     = 2;
    localparam int ERR_OVR     = 3;
    localparam int ERR_TIMEOUT = 4;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] slave_addr;
        logic [CNT_W-1:0]  tx_count;
        logic [CNT_W-1:0]  rx_count;
        logic [FLAG_W-1:0] status_flags;
    } req_t;

    typedef struct packed {
        logic               issue_setup;
        logic [CHUNK_W-1:0] chunk_count;
        logic               read_not_write;
        logic               reload_flag;
        logic [ADDR_W-1:0]  bus_address;
        logic               issue_start;
        logic               issue_stop;
        logic               finish_ok;
        logic               finish_error;
        logic [ERR_W-1:0]   error_bits;
    } rsp_t;

endpackage

>>> rtl/i2c_mts_req_if.sv
// request channel of the i2c master transfer sequencer
// depends on i2c_mts_pkg for field widths
interface i2c_mts_req_if
    import i2c_mts_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [ADDR_W-1:0] slave_addr;
    logic [CNT_W-1:0]  tx_count;
    logic [CNT_W-1:0]  rx_count;
    logic [FLAG_W-1:0] status_flags;

    modport source (
        output valid, func, slave_addr, tx_count, rx_count, status_flags,
        input  ready
    );

    modport sink (
        input  valid, func, slave_addr, tx_count, rx_count, status_flags,
        output ready
    );
endinterface

>>> rtl/i2c_mts_rsp_if.sv
// result channel of the i2c master transfer sequencer
// depends on i2c_mts_pkg for field widths
interface i2c_mts_rsp_if
    import i2c_mts_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               issue_setup;
    logic [CHUNK_W-1:0] chunk_count;
    logic               read_not_write;
    logic               reload_flag;
    logic [ADDR_W-1:0]  bus_address;
    logic               issue_start;
    logic               issue_stop;
    logic               finish_ok;
    logic               finish_error;
    logic [ERR_W-1:0]   error_bits;

    modport source (
        output valid, issue_setup, chunk_count, read_not_write, reload_flag,
               bus_address, issue_start, issue_stop, finish_ok, finish_error,
               error_bits,
        input  ready
    );

    modport sink (
        input  valid, issue_setup, chunk_count, read_not_write, reload_flag,
               bus_address, issue_start, issue_stop, finish_ok, finish_error,
               error_bits,
        output ready
    );
endinterface

>>> rtl/i2c_mts_core.sv
// sequencing logic: next transaction state and the result for one request
// depends on i2c_mts_pkg
module i2c_mts_core
    import i2c_mts_pkg::*;
#(
    parameter int CHUNK_MAX   = CHUNK_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   ten_bit,
    input  req_t                   req,
    input  logic                   phase_reg,
    input  logic [COUNT_WIDTH-1:0] remain_reg,
    input  logic [COUNT_WIDTH-1:0] pend_reg,
    input  logic [ERR_W-1:0]       err_reg,
    input  logic [ADDR_W-1:0]      addr_reg,
    output logic                   phase_next,
    output logic [COUNT_WIDTH-1:0] remain_next,
    output logic [COUNT_WIDTH-1:0] pend_next,
    output logic [ERR_W-1:0]       err_next,
    output logic [ADDR_W-1:0]      addr_next,
    output rsp_t                   rsp
);

    localparam logic [COUNT_WIDTH-1:0] CHUNK_N = COUNT_WIDTH'(CHUNK_MAX);

    logic                   setup_en;
    logic [COUNT_WIDTH-1:0] setup_n;
    logic                   setup_rd;
    logic                   over;
    logic                   fin;
    logic                   err_stop;
    logic                   start;

    always_comb
    begin
        setup_en   = 1'b0;
        setup_n    = '0;
        setup_rd   = 1'b0;
        fin        = 1'b0;
        err_stop   = 1'b0;
        start      = 1'b0;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        addr_next  = addr_reg;
        case (req.func)
            FUNC_START_WR, FUNC_START_RD:
            begin
                err_next  = '0;
                addr_next = ten_bit ? req.slave_addr
                                    : {2'b00, req.slave_addr[6:0], 1'b0};
                start     = 1'b1;
                setup_en  = 1'b1;
                if (req.func == FUNC_START_WR)
                begin
                    pend_next  = COUNT_WIDTH'(req.rx_count);
                    phase_next = 1'b0;
                    setup_n    = COUNT_WIDTH'(req.tx_count);
                    setup_rd   = 1'b0;
                end
                else
                begin
                    pend_next  = '0;
                    phase_next = 1'b1;
                    setup_n    = COUNT_WIDTH'(req.rx_count);
                    setup_rd   = 1'b1;
                end
            end
            FUNC_EVENT:
            begin
                if (req.status_flags[FLAG_OTHER_ER:FLAG_BUS] != '0)
                begin
                    // error event: merge error bits, other flags ignored
                    err_next = err_reg | {req.status_flags[FLAG_TIMEOUT:FLAG_BUS], 1'b0};
                    err_stop = (err_next != '0);
                end
                else if (req.status_flags[FLAG_NACK])
                begin
                    err_next           = err_reg;
                    err_next[ERR_ACK]  = 1'b1;
                    fin                = 1'b1;
                end
                else if (req.status_flags[FLAG_RELOAD])
                begin
                    setup_en = 1'b1;
                    setup_n  = remain_reg;
                    setup_rd = phase_reg;
                end
                else if (req.status_flags[FLAG_COMPLETE] && !phase_reg && pend_reg != '0)
                begin
                    // repeated start into the read phase
                    setup_en   = 1'b1;
                    setup_n    = pend_reg;
                    setup_rd   = 1'b1;
                    pend_next  = '0;
                    phase_next = 1'b1;
                    start      = 1'b1;
                end
                else if (req.status_flags[FLAG_COMPLETE] || req.status_flags[FLAG_OTHER])
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign over        = (setup_n > CHUNK_N);
    assign remain_next = !setup_en ? remain_reg : (over ? setup_n - CHUNK_N : '0);

    always_comb
    begin
        rsp                = '0;
        rsp.issue_setup    = setup_en;
        rsp.chunk_count    = setup_en ? (over ? CHUNK_N[CHUNK_W-1:0] : setup_n[CHUNK_W-1:0])
                                      : '0;
        rsp.read_not_write = setup_en & setup_rd;
        rsp.reload_flag    = setup_en & over;
        rsp.bus_address    = addr_next;
        rsp.issue_start    = start;
        rsp.issue_stop     = fin;
        rsp.finish_ok      = fin && (err_next == '0);
        rsp.finish_error   = (fin && (err_next != '0)) || err_stop;
        rsp.error_bits     = err_next;
    end

endmodule

>>> rtl/i2c_master_transfer_sequencer.sv
// top level of the i2c master transfer sequencer: state, config, result register
// depends on i2c_mts_pkg, i2c_mts_req_if, i2c_mts_rsp_if and i2c_mts_core
//
// usage:
//   req carries start requests (write-then-read or read-only, with slave
//   address and byte counts) and status events with the peripheral flags.
//   rsp returns exactly one result per request: chunk setup (count, direction,
//   reload), formatted address, start/stop strobes, finish and error bits.
//   cfg_we/cfg_wdata write the ten-bit addressing mode; write it only while
//   no request is in flight, it is sampled on start requests.
// timing:
//   a request is processed in the cycle it is accepted and its result shows
//   on rsp the next cycle. one request per cycle is accepted while rsp is
//   not stalled, set by the single result register; the state update is one
//   pass of small adders and compares.
//   when rsp is stalled the result register holds and req.ready drops until
//   the result is taken; a request can be accepted in the same cycle the
//   held result leaves.
// reset:
//   rst_n clears the sequencer state, the addressing mode and the result
//   valid; the block is ready right after reset.
module i2c_master_transfer_sequencer
    import i2c_mts_pkg::*;
#(
    parameter int CHUNK_MAX   = CHUNK_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    i2c_mts_req_if.sink   req,
    i2c_mts_rsp_if.source rsp
);

    logic                   ten_bit_reg;
    logic                   phase_reg;
    logic [COUNT_WIDTH-1:0] remain_reg;
    logic [COUNT_WIDTH-1:0] pend_reg;
    logic [ERR_W-1:0]       err_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   phase_next;
    logic [COUNT_WIDTH-1:0] remain_next;
    logic [COUNT_WIDTH-1:0] pend_next;
    logic [ERR_W-1:0]       err_next;
    logic [ADDR_W-1:0]      addr_next;
    logic                   valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    req_t                   req_item;
    logic                   accept;

    assign req_item.func         = req.func;
    assign req_item.slave_addr   = req.slave_addr;
    assign req_item.tx_count     = req.tx_count;
    assign req_item.rx_count     = req.rx_count;
    assign req_item.status_flags = req.status_flags;

    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    i2c_mts_core #(
        .CHUNK_MAX   (CHUNK_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .ten_bit     (ten_bit_reg),
        .req         (req_item),
        .phase_reg   (phase_reg),
        .remain_reg  (remain_reg),
        .pend_reg    (pend_reg),
        .err_reg     (err_reg),
        .addr_reg    (addr_reg),
        .phase_next  (phase_next),
        .remain_next (remain_next),
        .pend_next   (pend_next),
        .err_next    (err_next),
        .addr_next   (addr_next),
        .rsp         (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_bit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            ten_bit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            remain_reg <= '0;
            pend_reg   <= '0;
            err_reg    <= '0;
            addr_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
            addr_reg   <= addr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.issue_setup    = rsp_reg.issue_setup;
    assign rsp.chunk_count    = rsp_reg.chunk_count;
    assign rsp.read_not_write = rsp_reg.read_not_write;
    assign rsp.reload_flag    = rsp_reg.reload_flag;
    assign rsp.bus_address    = rsp_reg.bus_address;
    assign rsp.issue_start    = rsp_reg.issue_start;
    assign rsp.issue_stop     = rsp_reg.issue_stop;
    assign rsp.finish_ok      = rsp_reg.finish_ok;
    assign rsp.finish_error   = rsp_reg.finish_error;
    assign rsp.error_bits     = rsp_reg.error_bits;

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.func == FUNC_START_WR || req.func == FUNC_START_RD)
        |=> rsp.valid && rsp.issue_start && rsp.issue_setup && rsp.error_bits == '0)
        else $error("start request did not produce a start with a chunk setup");

    a_finish_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.finish_ok |-> !rsp.finish_error && rsp.error_bits == '0
            && rsp.issue_stop)
        else $error("finish ok with errors or without stop");

    a_reload_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.reload_flag
        |-> rsp.issue_setup && rsp.chunk_count == CHUNK_MAX[CHUNK_W-1:0])
        else $error("reload flagged on a partial chunk");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(remain_reg) && $stable(pend_reg) && $stable(err_reg))
        else $error("sequencer state changed without a request");

endmodule

>>> bench/testbench.sv
// self-checking bench for the i2c master transfer sequencer top level
// depends on i2c_mts_pkg, i2c_mts_req_if, i2c_mts_rsp_if and the rtl under test
// runs a directed list of requests and then random transfers against a cycle-free predictor
module testbench;
    import i2c_mts_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [FLAG_W-1:0] F_NACK     = FLAG_W'(1 << FLAG_NACK);
    localparam logic [FLAG_W-1:0] F_RELOAD   = FLAG_W'(1 << FLAG_RELOAD);
    localparam logic [FLAG_W-1:0] F_COMPLETE = FLAG_W'(1 << FLAG_COMPLETE);
    localparam logic [FLAG_W-1:0] F_BUS      = FLAG_W'(1 << FLAG_BUS);
    localparam logic [FLAG_W-1:0] F_ARB      = FLAG_W'(1 << FLAG_ARB);
    localparam logic [FLAG_W-1:0] F_OVR      = FLAG_W'(1 << FLAG_OVR);
    localparam logic [FLAG_W-1:0] F_TIMEOUT  = FLAG_W'(1 << FLAG_TIMEOUT);
    localparam logic [FLAG_W-1:0] F_OTHER_ER = FLAG_W'(1 << FLAG_OTHER_ER);
    localparam logic [FLAG_W-1:0] F_OTHER    = FLAG_W'(1 << FLAG_OTHER);
    localparam logic [FLAG_W-1:0] F_ERRORS   = F_BUS | F_ARB | F_OVR | F_TIMEOUT | F_OTHER_ER;

    localparam int IDLE_PCT      = 31;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 116;
    localparam int PRINT_CAP     = 40;

    typedef enum logic {ROW_REQUEST, ROW_MODE} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic      mode;
        req_t      item;
        logic      typed;
        rsp_t      want;
    } stim_row_t;

    localparam rsp_t NO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    i2c_mts_req_if req_ch ();
    i2c_mts_rsp_if rsp_ch ();

    i2c_master_transfer_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #10 clk = ~clk;

    // predictor copy of the sequencer state
    logic              mode_ten_bit;
    logic              seq_phase_rd;
    logic [CNT_W-1:0]  seq_left;
    logic [CNT_W-1:0]  seq_rd_owed;
    logic [ERR_W-1:0]  seq_errs;
    logic [ADDR_W-1:0] seq_addr;
    bit                xfer_open;
    bit                calm;

    rsp_t      sequencer_outputs[$];
    stim_row_t stim_rows[$];

    int faults;
    int n_requests;
    int n_directed;
    int n_results;
    int n_mode_writes;

    task automatic report_fault(string msg);
        if (faults < PRINT_CAP)
            $display("%0t: %s", $time, msg);
        faults++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_fault($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    function automatic rsp_t load_chunk(logic [CNT_W-1:0] n, logic rd, rsp_t o);
        if (n > CHUNK_MAX_DEF) begin
            seq_left      = n - CNT_W'(CHUNK_MAX_DEF);
            o.chunk_count = CHUNK_W'(CHUNK_MAX_DEF);
            o.reload_flag = 1'b1;
        end
        else begin
            seq_left      = '0;
            o.chunk_count = n[CHUNK_W-1:0];
            o.reload_flag = 1'b0;
        end
        o.issue_setup    = 1'b1;
        o.read_not_write = rd;
        return o;
    endfunction

    function automatic rsp_t close_xfer(rsp_t o);
        o.issue_stop = 1'b1;
        if (seq_errs != '0)
            o.finish_error = 1'b1;
        else
            o.finish_ok = 1'b1;
        return o;
    endfunction

    function automatic rsp_t advance_sequencer(req_t r);
        rsp_t o;
        logic rd;
        o  = '0;
        rd = (r.func == FUNC_START_RD);
        case (r.func)
            FUNC_START_WR, FUNC_START_RD:
            begin
                seq_rd_owed = rd ? '0 : r.rx_count;
                seq_errs    = '0;
                if (mode_ten_bit)
                    seq_addr = r.slave_addr;
                else
                    seq_addr = {2'b00, r.slave_addr[6:0], 1'b0};
                seq_phase_rd  = rd;
                o             = load_chunk(rd ? r.rx_count : r.tx_count, rd, o);
                o.issue_start = 1'b1;
            end
            FUNC_EVENT:
            begin
                // any error flag masks the rest of the event
                if (|r.status_flags[FLAG_OTHER_ER:FLAG_BUS]) begin
                    if (r.status_flags[FLAG_BUS])     seq_errs[ERR_BUS]     = 1'b1;
                    if (r.status_flags[FLAG_ARB])     seq_errs[ERR_ARB]     = 1'b1;
                    if (r.status_flags[FLAG_OVR])     seq_errs[ERR_OVR]     = 1'b1;
                    if (r.status_flags[FLAG_TIMEOUT]) seq_errs[ERR_TIMEOUT] = 1'b1;
                    if (seq_errs != '0)
                        o.finish_error = 1'b1;
                end
                else if (!r.status_flags[FLAG_OTHER] &&
                         r.status_flags[FLAG_COMPLETE:FLAG_NACK] == '0) begin
                    o = o;
                end
                else if (r.status_flags[FLAG_NACK]) begin
                    seq_errs[ERR_ACK] = 1'b1;
                    o = close_xfer(o);
                end
                else if (r.status_flags[FLAG_RELOAD]) begin
                    o = load_chunk(seq_left, seq_phase_rd, o);
                end
                else if (r.status_flags[FLAG_COMPLETE] && !seq_phase_rd &&
                         seq_rd_owed != '0) begin
                    // repeated start into the read phase
                    o             = load_chunk(seq_rd_owed, 1'b1, o);
                    seq_rd_owed   = '0;
                    seq_phase_rd  = 1'b1;
                    o.issue_start = 1'b1;
                end
                else begin
                    o = close_xfer(o);
                end
            end
            default:
            begin
                o = o;
            end
        endcase
        o.bus_address = seq_addr;
        o.error_bits  = seq_errs;
        return o;
    endfunction

    function automatic req_t request(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                     logic [CNT_W-1:0] tx, logic [CNT_W-1:0] rx,
                                     logic [FLAG_W-1:0] flags);
        req_t r;
        r.func         = func;
        r.slave_addr   = addr;
        r.tx_count     = tx;
        r.rx_count     = rx;
        r.status_flags = flags;
        return r;
    endfunction

    function automatic rsp_t outcome(logic setup, logic [CHUNK_W-1:0] chunk, logic rnw,
                                     logic more, logic [ADDR_W-1:0] addr, logic start,
                                     logic stop, logic ok, logic errf,
                                     logic [ERR_W-1:0] errs);
        rsp_t o;
        o.issue_setup    = setup;
        o.chunk_count    = chunk;
        o.read_not_write = rnw;
        o.reload_flag    = more;
        o.bus_address    = addr;
        o.issue_start    = start;
        o.issue_stop     = stop;
        o.finish_ok      = ok;
        o.finish_error   = errf;
        o.error_bits     = errs;
        return o;
    endfunction

    function automatic void add_request(req_t item, logic typed, rsp_t want);
        stim_row_t row;
        row.kind  = ROW_REQUEST;
        row.mode  = 1'b0;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_mode(logic v);
        stim_row_t row;
        row.kind  = ROW_MODE;
        row.mode  = v;
        row.item  = '0;
        row.typed = 1'b0;
        row.want  = NO_RESULT;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return CNT_W'($urandom_range(0, 300));
        if (roll < 85)
            return CNT_W'($urandom_range(0, 800));
        if (roll < 97)
            return CNT_W'($urandom_range(0, 3000));
        return CNT_W'($urandom);
    endfunction

    // mostly well-formed transfers, with restarts, nacks, errors and stray events mixed in
    function automatic req_t make_item();
        req_t r;
        int   roll;
        r = request(FUNC_EVENT, ADDR_W'($urandom), CNT_W'($urandom), CNT_W'($urandom), '0);
        roll = $urandom_range(0, 99);
        if (!xfer_open || roll < 4) begin
            r.func     = $urandom_range(0, 1) ? FUNC_START_RD : FUNC_START_WR;
            r.tx_count = pick_count();
            r.rx_count = pick_count();
        end
        else if (roll < 16) begin
            case ($urandom_range(0, 4))
                0:
                begin
                    r.func         = 2'($urandom);
                    r.status_flags = FLAG_W'($urandom);
                end
                1: r.status_flags = F_NACK | ($urandom_range(0, 1) ? F_OTHER : FLAG_W'(0));
                2: r.status_flags = (FLAG_W'($urandom_range(1, 31)) << FLAG_BUS) |
                                    FLAG_W'($urandom_range(0, 7));
                3: r.status_flags = F_OTHER;
                default: r.status_flags = '0;
            endcase
        end
        else if (seq_left != '0) begin
            r.status_flags = F_RELOAD | ($urandom_range(0, 1) ? F_COMPLETE : FLAG_W'(0));
        end
        else begin
            r.status_flags = F_COMPLETE | ($urandom_range(0, 3) == 0 ? F_OTHER : FLAG_W'(0));
        end
        return r;
    endfunction

    task automatic drive_request(req_t item, logic typed, rsp_t want);
        rsp_t predicted;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= item.func;
        req_ch.slave_addr   <= item.slave_addr;
        req_ch.tx_count     <= item.tx_count;
        req_ch.rx_count     <= item.rx_count;
        req_ch.status_flags <= item.status_flags;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = advance_sequencer(item);
        if (predicted.issue_start)
            xfer_open = 1'b1;
        if (predicted.issue_stop || predicted.finish_error)
            xfer_open = 1'b0;
        sequencer_outputs.push_back(typed ? want : predicted);
        n_requests++;
    endtask

    task automatic wait_quiet();
        while (sequencer_outputs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        req_ch.valid <= 1'b0;
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        mode_ten_bit  = v;
        n_mode_writes++;
    endtask

    initial
    begin : result_side
        rsp_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                if (sequencer_outputs.size() == 0) begin
                    report_fault("result with no request outstanding");
                end
                else begin
                    want = sequencer_outputs.pop_front();
                    check_field("issue_setup", 16'(rsp_ch.issue_setup),
                                16'(want.issue_setup));
                    check_field("chunk_count", 16'(rsp_ch.chunk_count),
                                16'(want.chunk_count));
                    check_field("read_not_write", 16'(rsp_ch.read_not_write),
                                16'(want.read_not_write));
                    check_field("reload_flag", 16'(rsp_ch.reload_flag),
                                16'(want.reload_flag));
                    check_field("bus_address", 16'(rsp_ch.bus_address),
                                16'(want.bus_address));
                    check_field("issue_start", 16'(rsp_ch.issue_start),
                                16'(want.issue_start));
                    check_field("issue_stop", 16'(rsp_ch.issue_stop),
                                16'(want.issue_stop));
                    check_field("finish_ok", 16'(rsp_ch.finish_ok),
                                16'(want.finish_ok));
                    check_field("finish_error", 16'(rsp_ch.finish_error),
                                16'(want.finish_error));
                    check_field("error_bits", 16'(rsp_ch.error_bits),
                                16'(want.error_bits));
                    n_results++;
                end
            end
            rsp_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        req_t      item;
        int        picked;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= '0;
        req_ch.slave_addr   <= '0;
        req_ch.tx_count     <= '0;
        req_ch.rx_count     <= '0;
        req_ch.status_flags <= '0;

        mode_ten_bit  = 1'b0;
        seq_phase_rd  = 1'b0;
        seq_left      = '0;
        seq_rd_owed   = '0;
        seq_errs      = '0;
        seq_addr      = '0;
        xfer_open     = 1'b0;
        calm          = 1'b0;
        faults        = 0;
        n_requests    = 0;
        n_directed    = 0;
        n_results     = 0;
        n_mode_writes = 0;

        // seven-bit addressing out of reset
        add_request(request(FUNC_EVENT, '0, '0, '0, '0), 1'b1, NO_RESULT);
        add_request(request(FUNC_UNUSED, '1, '1, '1, '1), 1'b1, NO_RESULT);
        add_request(request(FUNC_START_WR, 10'h3FF, 16'd0, 16'd0, '0), 1'b1,
                    outcome(1'b1, 8'd0, 1'b0, 1'b0, 10'h0FE, 1'b1, 1'b0, 1'b0, 1'b0, 5'h00));
        add_request(request(FUNC_EVENT, '0, '0, '0, F_COMPLETE), 1'b1,
                    outcome(1'b0, 8'd0, 1'b0, 1'b0, 10'h0FE, 1'b0, 1'b1, 1'b1, 1'b0, 5'h00));
        // multi-chunk write then read, reload wins over complete
        add_request(request(FUNC_START_WR, 10'h055, 16'd600, 16'd300, '0), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_RELOAD), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_RELOAD | F_COMPLETE), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_COMPLETE), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_RELOAD), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_COMPLETE), 1'b0, NO_RESULT);
        add_request(request(FUNC_START_RD, 10'h000, 16'd0, 16'hFFFF, '0), 1'b1,
                    outcome(1'b1, 8'hFF, 1'b1, 1'b1, 10'h000, 1'b1, 1'b0, 1'b0, 1'b0, 5'h00));
        add_request(request(FUNC_EVENT, '0, '0, '0, F_NACK), 1'b1,
                    outcome(1'b0, 8'd0, 1'b0, 1'b0, 10'h000, 1'b0, 1'b1, 1'b0, 1'b1, 5'h01));
        add_request(request(FUNC_EVENT, '0, '0, '0, F_ERRORS), 1'b1,
                    outcome(1'b0, 8'd0, 1'b0, 1'b0, 10'h000, 1'b0, 1'b0, 1'b0, 1'b1, 5'h1F));
        // ten-bit addressing
        add_mode(1'b1);
        add_request(request(FUNC_START_WR, 10'h3FF, 16'hFFFF, 16'hFFFF, '0), 1'b1,
                    outcome(1'b1, 8'hFF, 1'b0, 1'b1, 10'h3FF, 1'b1, 1'b0, 1'b0, 1'b0, 5'h00));
        add_request(request(FUNC_EVENT, '0, '0, '0, F_OTHER_ER), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_OTHER), 1'b1,
                    outcome(1'b0, 8'd0, 1'b0, 1'b0, 10'h3FF, 1'b0, 1'b1, 1'b1, 1'b0, 5'h00));
        add_request(request(FUNC_EVENT, '0, '0, '0, '1), 1'b0, NO_RESULT);
        add_request(request(FUNC_START_WR, 10'h200, 16'd10, 16'd5, '0), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_NACK | F_OTHER), 1'b0, NO_RESULT);
        // chunk boundaries and a zero-byte reload
        add_mode(1'b0);
        add_request(request(FUNC_START_RD, 10'h07F, 16'd0, 16'd255, '0), 1'b0, NO_RESULT);
        add_request(request(FUNC_START_RD, 10'h380, 16'd0, 16'd256, '0), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_RELOAD), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_RELOAD), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_COMPLETE), 1'b0, NO_RESULT);
        add_request(request(FUNC_START_WR, 10'h001, 16'd0, 16'd7, '0), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_COMPLETE), 1'b0, NO_RESULT);
        add_request(request(FUNC_EVENT, '0, '0, '0, F_TIMEOUT), 1'b0, NO_RESULT);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_MODE) begin
                write_mode(row.mode);
            end
            else begin
                drive_request(row.item, row.typed, row.want);
                n_directed++;
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < RANDOM_PHASES - 2)
                write_mode(ph % 2 == 0);
            else
                write_mode(1'($urandom_range(0, 1)));
            // one whole phase runs back to back on both sides
            calm   = (ph == 2);
            picked = 0;
            while (picked < PHASE_ITEMS)
            begin
                item = make_item();
                drive_request(item, 1'b0, NO_RESULT);
                if (!(item.func == FUNC_UNUSED ||
                      (item.func == FUNC_EVENT && item.status_flags == '0)))
                    picked++;
            end
        end
        calm = 1'b0;

        req_ch.valid <= 1'b0;
        wait_quiet();
        repeat (4) @(posedge clk);

        $display("%0d requests driven (%0d directed), %0d results compared, %0d mode writes",
                 n_requests, n_directed, n_results, n_mode_writes);
        $display("random transfers mixed chunked reads and writes with nacks, errors and restarts");
        if (faults == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("testbench failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/i2c_mts_pkg.sv
rtl/i2c_mts_req_if.sv
rtl/i2c_mts_rsp_if.sv
rtl/i2c_mts_core.sv
rtl/i2c_master_transfer_sequencer.sv
bench/testbench.sv
